/* rtl/core/sefb_pkg.sv */
package sefb_pkg;

	localparam logic [7:0]  FRAME_STX   = 8'h02;
	localparam logic [7:0]  FRAME_ETX   = 8'h03;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  MAX_PAYLOAD = 8'd252;

	// configuration register indexes
	localparam logic REG_DEVICE_ID  = 1'b0;
	localparam logic REG_INCLUDE_ID = 1'b1;

	// one classified payload byte, as handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [7:0] len_byte;
		logic [7:0] dev_id;
		logic       with_id;
	} cmd_t;

	typedef enum logic [6:0] {
		PH_STX  = 7'b0000001,
		PH_LEN  = 7'b0000010,
		PH_ID   = 7'b0000100,
		PH_DATA = 7'b0001000,
		PH_CRCH = 7'b0010000,
		PH_CRCL = 7'b0100000,
		PH_ETX  = 7'b1000000
	} phase_t;

	// crc-16/modbus, one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/sefb_front.sv */
module sefb_front
	import sefb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_data,
	input  logic [7:0]  in_len,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        push_ready
);

	logic       in_frame_q;
	logic [7:0] bytes_left_q;
	logic [7:0] device_id_q;
	logic       include_id_q;
	logic [7:0] len_clamped;
	logic [7:0] left_next;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	always_comb begin
		if (in_len == 8'd0) begin
			len_clamped = 8'd1;
		end else if (in_len > MAX_PAYLOAD) begin
			len_clamped = MAX_PAYLOAD;
		end else begin
			len_clamped = in_len;
		end
	end

	always_comb begin
		if (!in_frame_q) begin
			left_next = len_clamped - 8'd1;
		end else if (bytes_left_q != 8'd0) begin
			left_next = bytes_left_q - 8'd1;
		end else begin
			left_next = bytes_left_q;
		end
	end

	always_comb begin
		push_cmd.data     = in_data;
		push_cmd.first    = !in_frame_q;
		push_cmd.last     = (left_next == 8'd0);
		push_cmd.len_byte = len_clamped + (include_id_q ? 8'd3 : 8'd2);
		push_cmd.dev_id   = device_id_q;
		push_cmd.with_id  = include_id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 8'd0;
			device_id_q  <= 8'd0;
			include_id_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEVICE_ID:  device_id_q  <= cfg_data;
					REG_INCLUDE_ID: include_id_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (push) begin
				bytes_left_q <= left_next;
				in_frame_q   <= (left_next != 8'd0);
			end
		end
	end

endmodule

/* rtl/core/sefb_queue.sv */
module sefb_queue
	import sefb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	input  logic pop,
	output cmd_t head_cmd,
	output logic head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/sefb_back.sv */
module sefb_back
	import sefb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head_cmd,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_end
);

	phase_t      phase_q;
	phase_t      cur_phase;
	phase_t      next_phase;
	logic        busy_q;
	logic        busy_next;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic [7:0]  byte_next;
	logic        advance;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;
	assign advance   = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		if (busy_q) begin
			cur_phase = phase_q;
		end else if (head_cmd.first) begin
			cur_phase = PH_STX;
		end else begin
			cur_phase = PH_DATA;
		end
	end

	always_comb begin
		byte_next  = head_cmd.data;
		crc_next   = crc_q;
		next_phase = cur_phase;
		busy_next  = 1'b1;
		pop        = 1'b0;
		case (cur_phase)
			PH_STX: begin
				byte_next  = FRAME_STX;
				next_phase = PH_LEN;
			end
			PH_LEN: begin
				byte_next  = head_cmd.len_byte;
				crc_next   = crc_byte(CRC_INIT, head_cmd.len_byte);
				next_phase = head_cmd.with_id ? PH_ID : PH_DATA;
			end
			PH_ID: begin
				byte_next  = head_cmd.dev_id;
				crc_next   = crc_byte(crc_q, head_cmd.dev_id);
				next_phase = PH_DATA;
			end
			PH_DATA: begin
				byte_next  = head_cmd.data;
				crc_next   = crc_byte(crc_q, head_cmd.data);
				next_phase = PH_CRCH;
				if (!head_cmd.last) begin
					busy_next = 1'b0;
					pop       = advance;
				end
			end
			PH_CRCH: begin
				byte_next  = crc_q[15:8];
				next_phase = PH_CRCL;
			end
			PH_CRCL: begin
				byte_next  = crc_q[7:0];
				next_phase = PH_ETX;
			end
			PH_ETX: begin
				byte_next = FRAME_ETX;
				crc_next  = CRC_INIT;
				busy_next = 1'b0;
				pop       = advance;
			end
			default: begin
				busy_next = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_next;
			out_end_q  <= (cur_phase == PH_ETX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STX;
			busy_q      <= 1'b0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= next_phase;
				busy_q      <= busy_next;
				crc_q       <= crc_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/stx_etx_frame_builder_crc16.sv */
// stx/etx frame builder with crc-16/modbus over length, id and payload
// path: a request accepted on s_* is queued, then its first byte is registered onto m_*
// throughput: one output byte per cycle while m_tready is high and the queue is not empty,
// set by the single output register; n-byte payload frames are n + 5 bytes (n + 6 with id)
// reset: arst_n clears the queue, frame state and output; include_id resets to 1
module stx_etx_frame_builder_crc16
	import sefb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// payload requests in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] payload_length
	// framed byte stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] tx_byte
	output logic        m_tlast    // frame_end, high on etx
);

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic push_ready;
	logic pop;
	logic head_valid;

	// front: tracks frame position, clamps length, tags first and last bytes
	sefb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata[7:0]),
		.in_len     (s_tdata[15:8]),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	// short queue decouples intake from header and trailer bubbles
	sefb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.head_cmd   (head_cmd),
		.head_valid (head_valid)
	);

	// back: per-byte sequencer that inserts header, crc and etx
	sefb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_end    (m_tlast)
	);

endmodule

/* verif/tb_stx_etx_frame_builder_crc16.sv */
`timescale 1ns / 100ps

module tb_stx_etx_frame_builder_crc16;
	import sefb_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 250;
	localparam int SETTLE_GAP   = 4;   // output register plus queue, rounded up
	localparam int MAX_REPORTS  = 20;

	// one byte of the framed stream as it should leave the block
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} framed_byte_t;

	// frame predictor: mirrors registers and framing state, queues the bytes
	// each accepted payload request must produce
	class frame_scoreboard;
		logic [7:0]   dev_id;
		logic         with_id;
		logic         open;
		logic [7:0]   remaining;
		logic [15:0]  crc;
		framed_byte_t frame_bytes_q[$];
		int           errors;
		int           checked;
		int           frames;
		int           id_frames;

		function new();
			dev_id    = 8'h00;
			with_id   = 1'b1;
			open      = 1'b0;
			remaining = 8'h00;
			crc       = CRC_INIT;
			errors    = 0;
			checked   = 0;
			frames    = 0;
			id_frames = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] value);
			if (idx == REG_DEVICE_ID) begin
				dev_id = value;
			end else begin
				with_id = value[0];
			end
		endfunction

		// modbus crc, shifted one bit at a time, lsb first
		function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c  = c >> 1;
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void put_byte(logic [7:0] b, logic eof);
			framed_byte_t fb;
			fb.tx_byte   = b;
			fb.frame_end = eof;
			frame_bytes_q.push_back(fb);
		endfunction

		function void absorb_payload(logic [7:0] data, logic [7:0] len_field);
			logic [7:0] n;
			logic [7:0] len_byte;
			if (!open) begin
				// length only counts on the opening byte; zero and oversize are clamped
				n = len_field;
				if (n == 8'd0) begin
					n = 8'd1;
				end
				if (n > MAX_PAYLOAD) begin
					n = MAX_PAYLOAD;
				end
				len_byte = n + (with_id ? 8'd3 : 8'd2);
				crc = CRC_INIT;
				put_byte(FRAME_STX, 1'b0);
				put_byte(len_byte, 1'b0);
				crc = crc_update(crc, len_byte);
				if (with_id) begin
					put_byte(dev_id, 1'b0);
					crc = crc_update(crc, dev_id);
					id_frames++;
				end
				open      = 1'b1;
				remaining = n - 8'd1;
				frames++;
			end else if (remaining > 0) begin
				remaining--;
			end
			put_byte(data, 1'b0);
			crc = crc_update(crc, data);
			if (remaining == 0) begin
				put_byte(crc[15:8], 1'b0);
				put_byte(crc[7:0], 1'b0);
				put_byte(FRAME_ETX, 1'b1);
				open = 1'b0;
				crc  = CRC_INIT;
			end
		endfunction

		function void check_byte(logic [7:0] tx, logic eof);
			framed_byte_t want;
			if (frame_bytes_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: unexpected output byte %02h last %b", $time, tx, eof);
				end
				return;
			end
			want = frame_bytes_q.pop_front();
			checked++;
			if (tx !== want.tx_byte) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: tx_byte mismatch, expected %02h actual %02h",
						$time, want.tx_byte, tx);
				end
			end
			if (eof !== want.frame_end) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: frame_end mismatch, expected %b actual %b",
						$time, want.frame_end, eof);
				end
			end
		endfunction

		function int pending();
			return frame_bytes_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] data_byte, [15:8] payload_length
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] tx_byte
	logic        m_tlast;   // frame_end

	frame_scoreboard sb;

	int  requests_sent;
	int  input_stall_cycles;
	int  cycle_count;
	bit  tx_burst;          // sender offers back to back when set
	bit  rx_burst;          // receiver always ready when set
	bit  squeeze_req;       // asks the receiver for one long hold-off
	bit  squeeze_done;

	stx_etx_frame_builder_crc16 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	// watchdog, plus a count of cycles the input sat blocked
	always @(posedge clk) begin
		cycle_count++;
		if (s_tvalid && !s_tready && arst_n) begin
			input_stall_cycles++;
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected",
				cycle_count, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// register write, one cycle of cfg_we, mirrored into the predictor
	task automatic write_reg(logic idx, logic [7:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// include_id write with junk in the unused upper bits
	task automatic write_include_id(logic on);
		logic [6:0] junk;
		junk = 7'($urandom_range(0, 127));
		write_reg(REG_INCLUDE_ID, {junk, on});
	endtask

	// stop offering and let the block run dry before touching registers
	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	// one payload request; tvalid stays up between back-to-back requests
	task automatic send_payload(logic [7:0] data, logic [7:0] len_field);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {len_field, data};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.absorb_payload(data, len_field);
		requests_sent++;
		@(negedge clk);
	endtask

	// full frame of random payload; later requests carry a random length field
	task automatic send_frame(logic [7:0] len_field);
		int n;
		n = (len_field == 0) ? 1 : ((len_field > MAX_PAYLOAD) ? MAX_PAYLOAD : len_field);
		for (int i = 0; i < n; i++) begin
			send_payload(8'($urandom_range(0, 255)),
				(i == 0) ? len_field : 8'($urandom_range(0, 255)));
		end
	endtask

	// receiver: random stalls, burst stretches, and one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				squeeze_req  = 1'b0;
				squeeze_done = 1'b1;
			end
			if ($urandom_range(0, 39) == 0) begin
				rx_burst = ~rx_burst;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do begin
				@(posedge clk);
			end while (!m_tvalid);
			sb.check_byte(m_tdata, m_tlast);
		end
	end

	// stimulus and end of run
	initial begin
		int         frame_no;
		int         pick;
		int         target;
		logic [7:0] len_field;

		sb                 = new();
		requests_sent      = 0;
		input_stall_cycles = 0;
		cycle_count        = 0;
		tx_burst           = 1'b0;
		rx_burst           = 1'b0;
		squeeze_req        = 1'b0;
		squeeze_done       = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_DEVICE_ID;
		cfg_data           = 8'h00;
		s_tvalid           = 1'b0;
		s_tdata            = 16'h0000;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, single byte frame, all-zero payload
		send_payload(8'h00, 8'd1);
		settle();
		// zero length is taken as one byte; device id at its top value
		write_reg(REG_DEVICE_ID, 8'hFF);
		send_payload(8'hFF, 8'd0);
		// short frame with edge data patterns
		send_payload(8'h80, 8'd3);
		send_payload(8'h01, 8'hFF);
		send_payload(8'h7F, 8'h00);
		settle();
		// frames without the id byte
		write_include_id(1'b0);
		tx_burst = 1'b1;
		send_payload(8'hA5, 8'd2);
		send_payload(8'h5A, 8'd2);
		tx_burst = 1'b0;
		// register writes in the middle of an open frame only count from the next one
		send_payload(8'h11, 8'd4);
		send_payload(8'h22, 8'd4);
		settle();
		write_reg(REG_DEVICE_ID, 8'h3C);
		write_include_id(1'b1);
		send_payload(8'h33, 8'd9);
		send_payload(8'h44, 8'd9);
		send_payload(8'hC3, 8'd1);
		settle();
		write_reg(REG_DEVICE_ID, 8'h00);

		// random frames, mostly short, a few long, one saturated
		target   = requests_sent + RANDOM_ITEMS;
		frame_no = 0;
		while (requests_sent < target) begin
			if (frame_no > 0 && $urandom_range(0, 4) == 0) begin
				settle();
				pick = $urandom_range(0, 3);
				write_reg(REG_DEVICE_ID, (pick == 0) ? 8'h00 :
					((pick == 1) ? 8'hFF : 8'($urandom_range(0, 255))));
				write_include_id(1'($urandom_range(0, 1)));
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			pick     = $urandom_range(0, 19);
			if (frame_no == 5) begin
				len_field = 8'($urandom_range(252, 255));
			end else if (pick == 0) begin
				len_field = 8'd0;
			end else if (pick < 3) begin
				len_field = 8'($urandom_range(13, 40));
			end else begin
				len_field = 8'($urandom_range(1, 8));
			end
			if (frame_no == 2) begin
				// output held off while input floods, fills the queue
				squeeze_req = 1'b1;
				tx_burst    = 1'b1;
				len_field   = 8'd30;
			end
			if (frame_no == 8) begin
				// sender waits for every outstanding byte before carrying on
				settle();
			end
			send_frame(len_field);
			frame_no++;
		end
		s_tvalid = 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("%0d payload requests in %0d frames (%0d with id), %0d bytes checked",
			requests_sent, sb.frames, sb.id_frames, sb.checked);
		$display("input blocked for %0d cycles; long output hold-off %s",
			input_stall_cycles, squeeze_done ? "exercised" : "missed");
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sefb_pkg.sv
rtl/core/sefb_front.sv
rtl/core/sefb_queue.sv
rtl/core/sefb_back.sv
rtl/core/stx_etx_frame_builder_crc16.sv
verif/tb_stx_etx_frame_builder_crc16.sv
